// ===== rtl/core/mtfrcb_pkg.sv =====
// Shared constants, control structs and state encodings for the
// move-to-front rank binarizer. No dependencies.

package mtfrcb_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int SYM_W       = 8;
    localparam int RANK_W      = 9;
    localparam int CTX_W       = 9;
    localparam int SIZE_BITS   = 30;
    localparam int CNT_W       = 5;
    localparam int GROUP_LEN   = 16;
    localparam int NUM_GROUPS  = TABLE_SIZE / GROUP_LEN;
    localparam int NODE_W      = 7;

    localparam logic [RANK_W-1:0] MARKER_RANK = 9'd256;
    localparam logic [RANK_W-1:0] CTX_CLAMP   = 9'd3;
    localparam logic [CTX_W-1:0]  CTX_RANK1   = 9'd4;
    localparam logic [CTX_W-1:0]  CTX_GROUP   = 9'd6;
    localparam logic [2:0]        LAST_GROUP  = 3'd7;

    typedef struct packed {
        logic               init;
        logic               shift;
        logic [SYM_W-1:0]   key;
        logic [SYM_W-1:0]   rank;
    } t_cell_ctl;

    typedef struct packed {
        logic                 start;
        logic                 hdr;
        logic [RANK_W-1:0]    rank;
        logic [1:0]           ctx_c;
        logic [SIZE_BITS-1:0] bsize;
    } t_emit_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FLAG0,
        PH_FLAG1,
        PH_GROUP,
        PH_OFFSET,
        PH_SIZE
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK1,
        ST_LOOK2,
        ST_START,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/core/mtf_rank_context_binarizer.sv =====
// Top level of the move-to-front rank binarizer: item control, the cell
// chain that holds the list, and the decision sequencer.
// Depends on mtfrcb_pkg, mtfrcb_table and mtfrcb_emit.

// The block takes one item at a time. A data byte passes through the cell
// chain (compare, then two registered stages of the rank encoder, the last of
// which starts the decisions) and is then sent as one decision per cycle while
// the output is not stalled, 1 to 16 of them, or 9 for a marker, before the
// block returns to idle. A header gives 30 decisions. The list is shifted at
// the edge that starts the decisions, and a header restores the identity list
// at once. Stalls on the output hold the decisions back.

module mtf_rank_context_binarizer
    import mtfrcb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_op,
    input  logic [SYM_W-1:0]     i_symbol,
    input  logic                 i_is_marker,
    input  logic [SIZE_BITS-1:0] i_block_size,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_decision_bit,
    output logic [CTX_W-1:0]     o_context_index,
    output logic                 o_raw_bit,
    output logic                 o_last_of_item
);

    t_state               r_state, n_state;
    logic                 r_op;
    logic [SYM_W-1:0]     r_sym;
    logic                 r_marker;
    logic [SIZE_BITS-1:0] r_bsize;
    logic [RANK_W-1:0]    r_prev_rank, n_prev_rank;
    logic                 w_accept;
    logic                 w_busy;
    logic [SYM_W-1:0]     w_rank;
    logic [RANK_W-1:0]    w_item_rank;
    t_cell_ctl            w_ctl;
    t_emit_cmd            w_cmd;

    assign w_accept    = i_valid && o_ready;
    assign w_item_rank = r_marker ? MARKER_RANK : RANK_W'(w_rank);

    always_comb begin
        n_state     = r_state;
        n_prev_rank = r_prev_rank;
        o_ready     = 1'b0;
        w_ctl.init  = 1'b0;
        w_ctl.shift = 1'b0;
        w_ctl.key   = r_sym;
        w_ctl.rank  = w_rank;
        w_cmd.start = 1'b0;
        w_cmd.hdr   = r_op;
        w_cmd.rank  = w_item_rank;
        w_cmd.ctx_c = (r_prev_rank > CTX_CLAMP) ? CTX_CLAMP[1:0] : r_prev_rank[1:0];
        w_cmd.bsize = r_bsize;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_op) begin
                        w_ctl.init  = 1'b1;
                        n_prev_rank = CTX_CLAMP;
                        n_state     = ST_START;
                    end else begin
                        n_state = ST_LOOK1;
                    end
                end
            end
            ST_LOOK1: begin
                n_state = ST_LOOK2;
            end
            ST_LOOK2: begin
                n_state = ST_START;
            end
            ST_START: begin
                w_cmd.start = 1'b1;
                if (!r_op) begin
                    n_prev_rank = w_item_rank;
                    w_ctl.shift = !r_marker;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!w_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev_rank <= CTX_CLAMP;
        end else begin
            r_state     <= n_state;
            r_prev_rank <= n_prev_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_op;
            r_sym    <= i_symbol;
            r_marker <= i_is_marker;
            r_bsize  <= i_block_size;
        end
    end

    mtfrcb_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_rank  (w_rank)
    );

    mtfrcb_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_busy          (w_busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_decision_bit  (o_decision_bit),
        .o_context_index (o_context_index),
        .o_raw_bit       (o_raw_bit),
        .o_last_of_item  (o_last_of_item)
    );

endmodule

// ===== rtl/core/mtfrcb_cell.sv =====
// One position of the move-to-front list: holds a symbol, compares it
// with the search key and takes its left neighbor's symbol on a shift
// if its position is not above the rank. Depends on mtfrcb_pkg.

module mtfrcb_cell
    import mtfrcb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SYM_W-1:0] i_pos,
    input  t_cell_ctl        i_ctl,
    input  logic [SYM_W-1:0] i_prev,
    output logic [SYM_W-1:0] o_val,
    output logic             o_match
);

    logic [SYM_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_val <= i_pos;
        end else if (i_ctl.shift && (i_pos <= i_ctl.rank)) begin
            r_val <= i_prev;
        end
    end

    assign o_val   = r_val;
    assign o_match = (r_val == i_ctl.key);

endmodule

// ===== rtl/core/mtfrcb_table.sv =====
// Chain of 256 list cells with a two-stage registered rank encoder.
// The rank of the key passes through the group registers, then the rank register.
// Depends on mtfrcb_pkg and mtfrcb_cell.

module mtfrcb_table
    import mtfrcb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    output logic [SYM_W-1:0] o_rank
);

    logic [SYM_W-1:0] w_val [TABLE_SIZE];
    logic             w_match [TABLE_SIZE];
    logic [SYM_W-1:0] r_grp [NUM_GROUPS];
    logic [SYM_W-1:0] n_grp [NUM_GROUPS];
    logic [SYM_W-1:0] r_rank;
    logic [SYM_W-1:0] n_rank;

    for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_cell
        logic [SYM_W-1:0] w_prev;
        if (k == 0) begin : g_head
            assign w_prev = i_ctl.key;
        end else begin : g_body
            assign w_prev = w_val[k-1];
        end
        mtfrcb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (SYM_W'(k)),
            .i_ctl   (i_ctl),
            .i_prev  (w_prev),
            .o_val   (w_val[k]),
            .o_match (w_match[k])
        );
    end

    always_comb begin
        for (int j = 0; j < NUM_GROUPS; j++) begin
            n_grp[j] = '0;
            for (int i = 0; i < GROUP_LEN; i++) begin
                if (w_match[j*GROUP_LEN + i]) begin
                    n_grp[j] = n_grp[j] | SYM_W'(j*GROUP_LEN + i);
                end
            end
        end
        n_rank = '0;
        for (int j = 0; j < NUM_GROUPS; j++) begin
            n_rank = n_rank | r_grp[j];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp  <= n_grp;
        r_rank <= n_rank;
    end

    assign o_rank = r_rank;

endmodule

// ===== rtl/core/mtfrcb_emit.sv =====
// Decision sequencer: turns a rank or a block size into a run of binary
// decisions with context numbers, behind a registered output stage.
// Depends on mtfrcb_pkg.

module mtfrcb_emit
    import mtfrcb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_emit_cmd        i_cmd,
    output logic             o_busy,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_decision_bit,
    output logic [CTX_W-1:0] o_context_index,
    output logic             o_raw_bit,
    output logic             o_last_of_item
);

    t_phase               r_phase, n_phase;
    logic [RANK_W-1:0]    r_rank;
    logic [1:0]           r_ctx_c;
    logic [2:0]           r_g, n_g;
    logic [2:0]           r_bidx, n_bidx;
    logic [NODE_W-1:0]    r_node, n_node;
    logic [SIZE_BITS-1:0] r_size, n_size;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_ovalid;
    logic                 r_obit, n_obit;
    logic [CTX_W-1:0]     r_octx, n_octx;
    logic                 r_oraw, n_oraw;
    logic                 r_olast, n_olast;
    logic                 w_adv;
    logic                 w_in_group;
    logic [CTX_W-1:0]     w_gbase;
    logic [SYM_W-1:0]     w_rank_lo;

    assign w_adv      = (r_phase != PH_IDLE) && (!r_ovalid || i_ready);
    assign w_in_group = ((r_rank >> ({1'b0, r_g} + 4'd1)) == '0);
    assign w_gbase    = CTX_GROUP + (CTX_W'(1) << r_g);
    assign w_rank_lo  = r_rank[SYM_W-1:0];

    always_comb begin
        n_phase = r_phase;
        n_g     = r_g;
        n_bidx  = r_bidx;
        n_node  = r_node;
        n_size  = r_size;
        n_cnt   = r_cnt;
        n_obit  = 1'b0;
        n_octx  = '0;
        n_oraw  = 1'b0;
        n_olast = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
            end
            PH_FLAG0: begin
                n_obit  = (r_rank == '0);
                n_octx  = CTX_W'(r_ctx_c);
                n_olast = (r_rank == '0);
                n_phase = (r_rank == '0) ? PH_IDLE : PH_FLAG1;
            end
            PH_FLAG1: begin
                n_obit  = (r_rank == RANK_W'(1));
                n_octx  = CTX_RANK1 + CTX_W'(r_ctx_c);
                n_olast = (r_rank == RANK_W'(1));
                n_phase = (r_rank == RANK_W'(1)) ? PH_IDLE : PH_GROUP;
                n_g     = 3'd1;
            end
            PH_GROUP: begin
                n_obit = w_in_group;
                n_octx = w_gbase;
                if (w_in_group) begin
                    n_phase = PH_OFFSET;
                    n_bidx  = r_g - 3'd1;
                    n_node  = NODE_W'(1);
                end else if (r_g == LAST_GROUP) begin
                    n_olast = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_g = r_g + 3'd1;
                end
            end
            PH_OFFSET: begin
                n_obit  = w_rank_lo[r_bidx];
                n_octx  = w_gbase + CTX_W'(r_node);
                n_node  = {r_node[NODE_W-2:0], w_rank_lo[r_bidx]};
                n_olast = (r_bidx == '0);
                if (r_bidx == '0) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_bidx = r_bidx - 3'd1;
                end
            end
            PH_SIZE: begin
                n_obit  = r_size[SIZE_BITS-1];
                n_oraw  = 1'b1;
                n_size  = {r_size[SIZE_BITS-2:0], 1'b0};
                n_olast = (r_cnt == CNT_W'(SIZE_BITS - 1));
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SIZE_BITS - 1)) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_ovalid <= 1'b0;
        end else if (i_cmd.start) begin
            r_phase <= i_cmd.hdr ? PH_SIZE : PH_FLAG0;
            r_rank  <= i_cmd.rank;
            r_ctx_c <= i_cmd.ctx_c;
            r_size  <= i_cmd.bsize;
            r_cnt   <= '0;
            if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end else if (w_adv) begin
            r_phase  <= n_phase;
            r_g      <= n_g;
            r_bidx   <= n_bidx;
            r_node   <= n_node;
            r_size   <= n_size;
            r_cnt    <= n_cnt;
            r_ovalid <= 1'b1;
            r_obit   <= n_obit;
            r_octx   <= n_octx;
            r_oraw   <= n_oraw;
            r_olast  <= n_olast;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_busy          = (r_phase != PH_IDLE);
    assign o_valid         = r_ovalid;
    assign o_decision_bit  = r_obit;
    assign o_context_index = r_octx;
    assign o_raw_bit       = r_oraw;
    assign o_last_of_item  = r_olast;

endmodule

// ===== sim/tb_mtf_rank_context_binarizer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mtf_rank_context_binarizer: a queue-fed driver, a monitor
// and a built-in move-to-front predictor that works out every expected decision.
// Depends on mtfrcb_pkg and the RTL of mtf_rank_context_binarizer.

module tb_mtf_rank_context_binarizer;
    import mtfrcb_pkg::*;

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_HEADER = 1'b1;
    localparam int   LIMIT     = 400000;
    localparam int   HOLD_LEN  = 400;

    typedef struct packed {
        logic                 op;
        logic [SYM_W-1:0]     symbol;
        logic                 is_marker;
        logic [SIZE_BITS-1:0] block_size;
    } t_mtf_item;

    typedef struct packed {
        logic             decision;
        logic [CTX_W-1:0] ctx_idx;
        logic             raw;
        logic             last_item;
    } t_mtf_decision;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_op = 1'b0;
    logic [SYM_W-1:0]     i_symbol = '0;
    logic                 i_is_marker = 1'b0;
    logic [SIZE_BITS-1:0] i_block_size = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_decision_bit;
    logic [CTX_W-1:0]     o_context_index;
    logic                 o_raw_bit;
    logic                 o_last_of_item;

    t_mtf_item     pending_q[$];
    t_mtf_decision decisions_q[$];
    t_mtf_item     next_item;
    t_mtf_decision want;
    logic          in_taken = 1'b0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          rx_hold = 1'b0;
    logic          pressure_go = 1'b0;
    int            cycle_cnt = 0;
    int            errors = 0;
    int            n_items = 0;
    int            n_headers = 0;
    int            n_markers = 0;
    int            n_checked = 0;
    int            max_rank = 0;

    logic [SYM_W-1:0]  sym_at_rank[TABLE_SIZE];
    logic [SYM_W-1:0]  rank_of_sym[TABLE_SIZE];
    logic [RANK_W-1:0] prev_rank;
    logic [SYM_W-1:0]  alphabet[8];
    logic [SYM_W-1:0]  last_sym = '0;

    mtf_rank_context_binarizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_symbol        (i_symbol),
        .i_is_marker     (i_is_marker),
        .i_block_size    (i_block_size),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_decision_bit  (o_decision_bit),
        .o_context_index (o_context_index),
        .o_raw_bit       (o_raw_bit),
        .o_last_of_item  (o_last_of_item)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_mtf_decision mk_decision(logic dec, logic [CTX_W-1:0] ctx, logic raw);
        t_mtf_decision d;
        d.decision  = dec;
        d.ctx_idx   = ctx;
        d.raw       = raw;
        d.last_item = 1'b0;
        return d;
    endfunction

    task automatic reset_list();
        for (int k = 0; k < TABLE_SIZE; k++) begin
            sym_at_rank[k] = SYM_W'(k);
            rank_of_sym[k] = SYM_W'(k);
        end
        prev_rank = CTX_CLAMP;
    endtask

    task automatic binarize_item(input t_mtf_item it);
        t_mtf_decision     seq[$];
        logic [RANK_W-1:0] rank;
        logic [RANK_W-1:0] base;
        logic [1:0]        c;
        logic [CTX_W-1:0]  cx0;
        logic [CTX_W-1:0]  node;
        logic [SYM_W-1:0]  off;
        logic              found;
        logic              b;
        logic              bitv;
        int                g;
        if (it.op == OP_HEADER) begin
            reset_list();
            for (int i = SIZE_BITS - 1; i >= 0; i--)
                seq.push_back(mk_decision(it.block_size[i], '0, 1'b1));
        end else begin
            c = (prev_rank < CTX_CLAMP) ? prev_rank[1:0] : CTX_CLAMP[1:0];
            rank = it.is_marker ? MARKER_RANK : {1'b0, rank_of_sym[it.symbol]};
            prev_rank = rank;
            seq.push_back(mk_decision(rank == 0, CTX_W'(c), 1'b0));
            found = (rank == 0);
            if (!found) begin
                seq.push_back(mk_decision(rank == 1, CTX_RANK1 + CTX_W'(c), 1'b0));
                found = (rank == 1);
            end
            for (g = 1; g <= int'(LAST_GROUP) && !found; g++) begin
                base = RANK_W'(1) << g;
                cx0  = CTX_GROUP + CTX_W'(base);
                b    = rank < (base << 1);
                seq.push_back(mk_decision(b, cx0, 1'b0));
                if (b) begin
                    off  = SYM_W'(rank - base);
                    node = CTX_W'(1);
                    for (int i = g - 1; i >= 0; i--) begin
                        bitv = off[i];
                        seq.push_back(mk_decision(bitv, cx0 + node, 1'b0));
                        node = {node[CTX_W-2:0], bitv};
                    end
                    found = 1'b1;
                end
            end
            if (found) begin
                for (int k = int'(rank[SYM_W-1:0]); k > 0; k--) begin
                    sym_at_rank[k] = sym_at_rank[k-1];
                    rank_of_sym[sym_at_rank[k]] = SYM_W'(k);
                end
                sym_at_rank[0] = it.symbol;
                rank_of_sym[it.symbol] = '0;
                if (int'(rank) > max_rank)
                    max_rank = int'(rank);
            end
        end
        seq[seq.size()-1].last_item = 1'b1;
        foreach (seq[k])
            decisions_q.push_back(seq[k]);
    endtask

    task automatic add_item(logic op, logic [SYM_W-1:0] sym, logic marker,
                            logic [SIZE_BITS-1:0] size);
        t_mtf_item it;
        it.op         = op;
        it.symbol     = sym;
        it.is_marker  = marker;
        it.block_size = size;
        pending_q.push_back(it);
    endtask

    // Mostly data bytes drawn from a small alphabet or repeated, so that low ranks and
    // the rank-dependent contexts come up often, mixed with arbitrary bytes, markers
    // and headers.
    task automatic add_random_stream(int n);
        int                   r;
        logic [SIZE_BITS-1:0] size;
        logic [SYM_W-1:0]     sym;
        foreach (alphabet[k])
            alphabet[k] = SYM_W'($urandom_range(255));
        for (int i = 0; i < n; i++) begin
            r    = $urandom_range(99);
            size = SIZE_BITS'($urandom());
            if (r < 4) begin
                case ($urandom_range(3))
                    0: size = '0;
                    1: size = '1;
                    default: ;
                endcase
                add_item(OP_HEADER, SYM_W'($urandom_range(255)), 1'($urandom_range(1)), size);
            end else if (r < 10) begin
                add_item(OP_DATA, SYM_W'($urandom_range(255)), 1'b1, size);
            end else begin
                r = $urandom_range(99);
                if (r < 40)
                    sym = SYM_W'($urandom_range(255));
                else if (r < 80)
                    sym = alphabet[$urandom_range(7)];
                else
                    sym = last_sym;
                last_sym = sym;
                add_item(OP_DATA, sym, 1'b0, size);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || i_valid || decisions_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Driver: a new item is offered only when the slot is empty or its transfer has
    // just completed, so valid stays high with a stable payload until accepted.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_q.pop_front();
                i_valid      <= 1'b1;
                i_op         <= next_item.op;
                i_symbol     <= next_item.symbol;
                i_is_marker  <= next_item.is_marker;
                i_block_size <= next_item.block_size;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || rx_hold)
            i_ready <= 1'b0;
        else
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = i_valid && o_ready;
            if (in_taken) begin
                next_item.op         = i_op;
                next_item.symbol     = i_symbol;
                next_item.is_marker  = i_is_marker;
                next_item.block_size = i_block_size;
                binarize_item(next_item);
                n_items++;
                if (i_op == OP_HEADER)
                    n_headers++;
                else if (i_is_marker)
                    n_markers++;
            end
            if (o_valid && i_ready) begin
                if (decisions_q.size() == 0) begin
                    $error("unexpected decision transfer: context_index %0d", o_context_index);
                    errors++;
                end else begin
                    want = decisions_q.pop_front();
                    n_checked++;
                    if (o_decision_bit !== want.decision) begin
                        $error("decision_bit: expected %0d, got %0d",
                               want.decision, o_decision_bit);
                        errors++;
                    end
                    if (o_context_index !== want.ctx_idx) begin
                        $error("context_index: expected %0d, got %0d",
                               want.ctx_idx, o_context_index);
                        errors++;
                    end
                    if (o_raw_bit !== want.raw) begin
                        $error("raw_bit: expected %0d, got %0d", want.raw, o_raw_bit);
                        errors++;
                    end
                    if (o_last_of_item !== want.last_item) begin
                        $error("last_of_item: expected %0d, got %0d",
                               want.last_item, o_last_of_item);
                        errors++;
                    end
                end
            end
        end
    end

    // Long output hold-off while the driver keeps offering items.
    initial begin
        wait (pressure_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles, %0d decisions still expected.",
                 cycle_cnt, decisions_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        reset_list();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_item(OP_HEADER, 8'hFF, 1'b1, 30'h0);
        add_item(OP_DATA, 8'd0, 1'b0, 30'h0);
        add_item(OP_DATA, 8'd0, 1'b0, 30'h3FFF_FFFF);
        add_item(OP_DATA, 8'd1, 1'b0, 30'h0);
        add_item(OP_DATA, 8'd1, 1'b0, 30'h0);
        add_item(OP_DATA, 8'd0, 1'b0, 30'h0);
        add_item(OP_DATA, 8'd2, 1'b0, 30'h0);
        add_item(OP_DATA, 8'd255, 1'b0, 30'h2AAA_AAAA);
        add_item(OP_DATA, 8'd200, 1'b0, 30'h1555_5555);
        add_item(OP_DATA, 8'hA5, 1'b1, 30'h3FFF_FFFF);
        add_item(OP_DATA, 8'd255, 1'b0, 30'h0);
        add_item(OP_DATA, 8'h5A, 1'b1, 30'h0);
        add_item(OP_DATA, 8'hFF, 1'b1, 30'h0);
        add_item(OP_HEADER, 8'h00, 1'b0, 30'h3FFF_FFFF);
        add_item(OP_DATA, 8'h00, 1'b1, 30'h0);
        add_item(OP_HEADER, 8'h80, 1'b0, 30'h2AAA_AAAA);
        add_item(OP_DATA, 8'd128, 1'b0, 30'h1555_5555);
        add_item(OP_DATA, 8'd127, 1'b0, 30'h0);
        add_item(OP_DATA, 8'd4, 1'b0, 30'h0);
        add_item(OP_DATA, 8'd15, 1'b0, 30'h0);
        add_item(OP_DATA, 8'd63, 1'b0, 30'h0);
        add_item(OP_DATA, 8'd31, 1'b0, 30'h0);
        add_item(OP_HEADER, 8'h7F, 1'b1, 30'h1555_5555);
        add_item(OP_DATA, 8'd254, 1'b0, 30'h0);
        wait_drained();

        send_idle_pct  = 53;
        recv_stall_pct = 0;
        add_random_stream(90);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 53;
        add_random_stream(90);
        wait_drained();

        send_idle_pct  = 12;
        recv_stall_pct = 12;
        add_random_stream(90);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go    = 1'b1;
        add_random_stream(90);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (decisions_q.size() != 0) begin
            $error("%0d expected decisions never arrived", decisions_q.size());
            errors++;
        end
        $display("Ran %0d items (%0d headers, %0d markers) under several idle and stall mixes,",
                 n_items, n_headers, n_markers);
        $display("checked %0d decisions, deepest data rank %0d, %0d mismatches.",
                 n_checked, max_rank, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
